/* src/pth_pkg.sv */
// ----------------------------------------------------------------------------
// pth_pkg
// Shared widths, layout matrix constants and the configuration struct for
// the pixel to hex cell mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package pth_pkg;

  localparam int FRAC_BITS = 16;

  localparam int PIX_W   = 16;
  localparam int INV_W   = 17;
  localparam int CELL_W  = 17;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 17;
  localparam int INV_FB  = 16;

  localparam int D_W = PIX_W + 1;
  localparam int P_W = D_W + INV_W;
  localparam int C_W = FRAC_BITS + 1;
  localparam int M_W = P_W + FRAC_BITS;
  localparam int S_W = M_W + 1;
  localparam int F_W = M_W + 2;
  localparam int T_B = INV_FB + FRAC_BITS;
  localparam int N_W = F_W - T_B + 1;
  localparam int R_W = N_W + 1;

  localparam logic HEX_POINTY_TOP = 1'b0;
  localparam logic HEX_FLAT_TOP   = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_LAYOUT_MODE = 3'd0,
    REG_ORIGIN_X    = 3'd1,
    REG_ORIGIN_Y    = 3'd2,
    REG_INV_SIZE_X  = 3'd3,
    REG_INV_SIZE_Y  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                    layout_mode;
    logic signed [PIX_W-1:0] origin_x;
    logic signed [PIX_W-1:0] origin_y;
    logic [INV_W-1:0]        inv_size_x;
    logic [INV_W-1:0]        inv_size_y;
  } cfg_t;

  localparam logic [INV_W-1:0] INV_ONE = INV_W'(1) << INV_FB;

  function automatic logic [63:0] pth_isqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = n;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - res - bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] K_WIDE =
    (pth_isqrt((ONE_WIDE * ONE_WIDE * 64'd4) / 64'd3) + 64'd1) >> 1;
  localparam logic [63:0] T_WIDE = ((ONE_WIDE * 64'd2) / 64'd3 + 64'd1) >> 1;
  localparam logic [63:0] W_WIDE = ((ONE_WIDE * 64'd4) / 64'd3 + 64'd1) >> 1;

  // 1/sqrt(3), 1/3 and 2/3 in Q(FRAC_BITS)
  localparam logic signed [C_W-1:0] K_C = $signed({1'b0, K_WIDE[FRAC_BITS-1:0]});
  localparam logic signed [C_W-1:0] T_C = $signed({1'b0, T_WIDE[FRAC_BITS-1:0]});
  localparam logic signed [C_W-1:0] W_C = $signed({1'b0, W_WIDE[FRAC_BITS-1:0]});

endpackage

`default_nettype wire

/* src/pth_cfg.sv */
// ----------------------------------------------------------------------------
// pth_cfg
// Configuration register file: layout, origin and reciprocal hex sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module pth_cfg
  import pth_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_wdata,
  output cfg_t                    cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAYOUT_MODE: cfg_nxt.layout_mode = cfg_wdata[0];
        REG_ORIGIN_X:    cfg_nxt.origin_x    = $signed(cfg_wdata[PIX_W-1:0]);
        REG_ORIGIN_Y:    cfg_nxt.origin_y    = $signed(cfg_wdata[PIX_W-1:0]);
        REG_INV_SIZE_X:  cfg_nxt.inv_size_x  = cfg_wdata[INV_W-1:0];
        REG_INV_SIZE_Y:  cfg_nxt.inv_size_y  = cfg_wdata[INV_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout_mode <= HEX_POINTY_TOP;
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.inv_size_x  <= INV_ONE;
      cfg_r.inv_size_y  <= INV_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/pth_scale.sv */
// ----------------------------------------------------------------------------
// pth_scale
// Origin subtraction and scaling by the reciprocal hex sizes (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module pth_scale
  import pth_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic signed [PIX_W-1:0] pixel_x,
  input  wire logic signed [PIX_W-1:0] pixel_y,
  input  wire cfg_t                    cfg,
  output logic                         px_valid,
  output logic signed [P_W-1:0]        px,
  output logic signed [P_W-1:0]        py
);

  logic                  v1_r;
  logic                  v2_r;
  logic signed [D_W-1:0] dx_r;
  logic signed [D_W-1:0] dy_r;
  logic signed [P_W-1:0] px_r;
  logic signed [P_W-1:0] py_r;

  logic signed [D_W-1:0]     dx_nxt;
  logic signed [D_W-1:0]     dy_nxt;
  logic signed [D_W+INV_W:0] mul_x;
  logic signed [D_W+INV_W:0] mul_y;

  assign dx_nxt = $signed({pixel_x[PIX_W-1], pixel_x})
                - $signed({cfg.origin_x[PIX_W-1], cfg.origin_x});
  assign dy_nxt = $signed({pixel_y[PIX_W-1], pixel_y})
                - $signed({cfg.origin_y[PIX_W-1], cfg.origin_y});

  assign mul_x = dx_r * $signed({1'b0, cfg.inv_size_x});
  assign mul_y = dy_r * $signed({1'b0, cfg.inv_size_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    px_r <= $signed(mul_x[P_W-1:0]);
    py_r <= $signed(mul_y[P_W-1:0]);
  end

  assign px_valid = v2_r;
  assign px       = px_r;
  assign py       = py_r;

endmodule

`default_nettype wire

/* src/pth_matrix.sv */
// ----------------------------------------------------------------------------
// pth_matrix
// Inverse layout matrix: products, axial q and r, then s = -q - r
// (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module pth_matrix
  import pth_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  px_valid,
  input  wire logic signed [P_W-1:0] px,
  input  wire logic signed [P_W-1:0] py,
  input  wire cfg_t                  cfg,
  output logic                       frac_valid,
  output logic signed [F_W-1:0]      fq,
  output logic signed [F_W-1:0]      fr,
  output logic signed [F_W-1:0]      fs
);

  logic                  v3_r;
  logic                  v4_r;
  logic                  v5_r;
  logic signed [M_W-1:0] pa_r;
  logic signed [M_W-1:0] pb_r;
  logic signed [M_W-1:0] pc_r;
  logic signed [S_W-1:0] sq_r;
  logic signed [S_W-1:0] sr_r;
  logic signed [F_W-1:0] fq_r;
  logic signed [F_W-1:0] fr_r;
  logic signed [F_W-1:0] fs_r;

  logic signed [C_W-1:0]     coef_a;
  logic signed [C_W-1:0]     coef_b;
  logic signed [C_W-1:0]     coef_c;
  logic signed [P_W-1:0]     opnd_c;
  logic signed [P_W+C_W-1:0] mul_a;
  logic signed [P_W+C_W-1:0] mul_b;
  logic signed [P_W+C_W-1:0] mul_c;
  logic signed [S_W-1:0]     pa_e;
  logic signed [S_W-1:0]     pb_e;
  logic signed [S_W-1:0]     pc_e;
  logic signed [S_W-1:0]     sq_nxt;
  logic signed [S_W-1:0]     sr_nxt;
  logic signed [F_W-1:0]     sq_e;
  logic signed [F_W-1:0]     sr_e;

  // pointy: a = K*px, b = T*py, c = W*py; flat: a = W*px, b = K*py, c = T*px
  always_comb begin
    if (cfg.layout_mode == HEX_FLAT_TOP) begin
      coef_a = W_C;
      coef_b = K_C;
      coef_c = T_C;
      opnd_c = px;
    end else begin
      coef_a = K_C;
      coef_b = T_C;
      coef_c = W_C;
      opnd_c = py;
    end
  end

  assign mul_a = px * coef_a;
  assign mul_b = py * coef_b;
  assign mul_c = opnd_c * coef_c;

  assign pa_e = $signed({pa_r[M_W-1], pa_r});
  assign pb_e = $signed({pb_r[M_W-1], pb_r});
  assign pc_e = $signed({pc_r[M_W-1], pc_r});

  always_comb begin
    if (cfg.layout_mode == HEX_FLAT_TOP) begin
      sq_nxt = pa_e;
      sr_nxt = pb_e - pc_e;
    end else begin
      sq_nxt = pa_e - pb_e;
      sr_nxt = pc_e;
    end
  end

  assign sq_e = $signed({sq_r[S_W-1], sq_r});
  assign sr_e = $signed({sr_r[S_W-1], sr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= px_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= $signed(mul_a[M_W-1:0]);
    pb_r <= $signed(mul_b[M_W-1:0]);
    pc_r <= $signed(mul_c[M_W-1:0]);
    sq_r <= sq_nxt;
    sr_r <= sr_nxt;
    fq_r <= sq_e;
    fr_r <= sr_e;
    fs_r <= -sq_e - sr_e;
  end

  assign frac_valid = v5_r;
  assign fq         = fq_r;
  assign fr         = fr_r;
  assign fs         = fs_r;

endmodule

`default_nettype wire

/* src/pth_round.sv */
// ----------------------------------------------------------------------------
// pth_round
// Cube rounding: magnitudes, half away from zero rounding with moved
// distance, rebuild of the coordinate that moved most, saturation
// (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module pth_round
  import pth_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  frac_valid,
  input  wire logic signed [F_W-1:0] fq,
  input  wire logic signed [F_W-1:0] fr,
  input  wire logic signed [F_W-1:0] fs,
  output logic                       cell_valid,
  output logic [CELL_W-1:0]          cell_q,
  output logic [CELL_W-1:0]          cell_r
);

  localparam logic [T_B-1:0]      HALF_D = T_B'(1) << (T_B - 1);
  localparam logic signed [R_W:0] SAT_HI = (R_W + 1)'(2 ** (CELL_W - 1) - 1);
  localparam logic signed [R_W:0] SAT_LO = -SAT_HI - (R_W + 1)'(1);

  function automatic logic [CELL_W-1:0] sat_cell(input logic signed [R_W:0] v);
    logic signed [R_W:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[CELL_W-1:0];
  endfunction

  logic                  v6_r;
  logic                  v7_r;
  logic                  v8_r;
  logic [2:0]            neg_r;
  logic [F_W-1:0]        mag_r  [3];
  logic signed [R_W-1:0] rnd_r  [3];
  logic [T_B-1:0]        dist_r [3];
  logic [CELL_W-1:0]     q_r;
  logic [CELL_W-1:0]     r_r;

  logic signed [F_W-1:0] fin    [3];
  logic [F_W-1:0]        mag_nxt  [3];
  logic signed [R_W-1:0] rnd_nxt  [3];
  logic [T_B-1:0]        dist_nxt [3];
  logic [T_B-1:0]        frac     [3];
  logic [N_W-1:0]        nmag     [3];
  logic signed [R_W:0]   rq_e;
  logic signed [R_W:0]   rr_e;
  logic signed [R_W:0]   rs_e;
  logic signed [R_W:0]   q_sel;
  logic signed [R_W:0]   r_sel;

  assign fin[0] = fq;
  assign fin[1] = fr;
  assign fin[2] = fs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i]  = fin[i][F_W-1] ? F_W'(-fin[i]) : F_W'(fin[i]);
      frac[i]     = mag_r[i][T_B-1:0];
      nmag[i]     = {1'b0, mag_r[i][F_W-1:T_B]} + N_W'(frac[i][T_B-1]);
      dist_nxt[i] = frac[i][T_B-1] ? T_B'(~frac[i] + 1'b1) : frac[i];
      rnd_nxt[i]  = neg_r[i] ? -$signed({1'b0, nmag[i]}) : $signed({1'b0, nmag[i]});
    end
  end

  assign rq_e = $signed({rnd_r[0][R_W-1], rnd_r[0]});
  assign rr_e = $signed({rnd_r[1][R_W-1], rnd_r[1]});
  assign rs_e = $signed({rnd_r[2][R_W-1], rnd_r[2]});

  // ties keep q, then keep r
  always_comb begin
    q_sel = rq_e;
    r_sel = rr_e;
    if (dist_r[0] > dist_r[1] && dist_r[0] > dist_r[2]) begin
      q_sel = -rr_e - rs_e;
    end else if (dist_r[1] > dist_r[2]) begin
      r_sel = -rq_e - rs_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v6_r <= frac_valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_r[i]  <= fin[i][F_W-1];
      mag_r[i]  <= mag_nxt[i];
      rnd_r[i]  <= rnd_nxt[i];
      dist_r[i] <= dist_nxt[i];
    end
    q_r <= sat_cell(q_sel);
    r_r <= sat_cell(r_sel);
  end

  assign cell_valid = v8_r;
  assign cell_q     = q_r;
  assign cell_r     = r_r;

  // rounded cube coordinates sum to -1, 0 or 1
  a_cube_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |-> ((rq_e + rr_e + rs_e) == 0 || (rq_e + rr_e + rs_e) == 1
              || (rq_e + rr_e + rs_e) == -1))
    else $error("rounded cube coordinates drift from zero sum");

  a_dist_half: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |-> (dist_r[0] <= HALF_D && dist_r[1] <= HALF_D && dist_r[2] <= HALF_D))
    else $error("rounding moved a coordinate by more than one half");

endmodule

`default_nettype wire

/* src/pixel_to_hex_cell.sv */
// ----------------------------------------------------------------------------
// pixel_to_hex_cell
// Maps a pixel position to the axial hex cell (q, r) that contains it, for
// pointy-top or flat-top layouts with configurable origin and hex size.
//
//   channel   ports                                   transfer
//   input     start, busy, in_pixel_x, in_pixel_y     start high, busy low
//   result    out_valid, out_cell_q, out_cell_r       out_valid high, 1 cycle
//   config    cfg_we, cfg_index, cfg_wdata            cfg_we high
//
// One item per clock; a result follows its input transfer through the
// eight register stages: subtract, scale, matrix products, q/r sums, s,
// magnitude, rounding, rebuild and saturate.
// busy stays low; the receiver cannot stall, so results leave as they come.
// Synchronous reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_to_hex_cell
  import pth_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [PIX_W-1:0] in_pixel_x,
  input  wire logic signed [PIX_W-1:0] in_pixel_y,
  output logic                         out_valid,
  output logic signed [CELL_W-1:0]     out_cell_q,
  output logic signed [CELL_W-1:0]     out_cell_r,
  input  wire logic                    cfg_we,
  input  wire logic [CIDX_W-1:0]       cfg_index,
  input  wire logic [CDATA_W-1:0]      cfg_wdata
);

  cfg_t                  cfg;
  logic                  px_valid;
  logic signed [P_W-1:0] px;
  logic signed [P_W-1:0] py;
  logic                  frac_valid;
  logic signed [F_W-1:0] fq;
  logic signed [F_W-1:0] fr;
  logic signed [F_W-1:0] fs;
  logic                  cell_valid;
  logic [CELL_W-1:0]     cell_q;
  logic [CELL_W-1:0]     cell_r;

  assign busy = 1'b0;

  pth_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pth_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .cfg      (cfg),
    .px_valid (px_valid),
    .px       (px),
    .py       (py)
  );

  pth_matrix u_matrix (
    .clk        (clk),
    .rst_n      (rst_n),
    .px_valid   (px_valid),
    .px         (px),
    .py         (py),
    .cfg        (cfg),
    .frac_valid (frac_valid),
    .fq         (fq),
    .fr         (fr),
    .fs         (fs)
  );

  pth_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .frac_valid (frac_valid),
    .fq         (fq),
    .fr         (fr),
    .fs         (fs),
    .cell_valid (cell_valid),
    .cell_q     (cell_q),
    .cell_r     (cell_r)
  );

  assign out_valid  = cell_valid;
  assign out_cell_q = $signed(cell_q);
  assign out_cell_r = $signed(cell_r);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 8))
    else $error("result without an input transfer eight cycles earlier");

endmodule

`default_nettype wire
